@@ rtl/core/bpfm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bpfm_pkg;

    localparam int DEFAULT_MAX_PATTERN = 32;
    localparam int PAT_BYTES           = 32;
    localparam int PAT_IDX_W           = 5;
    localparam int LEN_CFG_W           = 6;
    localparam int CFG_DATA_W          = 64;
    localparam int CFG_INDEX_W         = 3;
    localparam int COUNT_W             = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW      = 3'd0,
        CFG_PATTERN_MID_LOW  = 3'd1,
        CFG_PATTERN_MID_HIGH = 3'd2,
        CFG_PATTERN_HIGH     = 3'd3,
        CFG_PATTERN_LENGTH   = 3'd4
    } bpfm_cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } bpfm_in_t;

    typedef struct packed {
        logic               match_found;
        logic [COUNT_W-1:0] match_offset;
    } bpfm_out_t;

    typedef struct packed {
        logic step;
        logic last;
    } bpfm_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/core/byte_pattern_first_match_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake          Beat
// s_       in   s_valid/s_ready    data_byte, last_byte
// m_       out  m_valid/m_ready    match_found, match_offset (one per image)
// cfg_     in   cfg_wr_en          cfg_index, cfg_wr_data
//
// One byte per cycle: a row of MAX_PATTERN window cells compares in parallel.
// A result is registered and appears in the cycle after the last byte of an image is taken.
// Non-last bytes are taken while a result waits; a last byte waits for m_ready.
// Reset is synchronous; stream state and the window clear after each image.

module byte_pattern_first_match_core #(
    parameter int MAX_PATTERN = bpfm_pkg::DEFAULT_MAX_PATTERN
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire bpfm_pkg::bpfm_in_t                 s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output bpfm_pkg::bpfm_out_t                     m_data,
    input  wire logic                               cfg_wr_en,
    input  wire logic [bpfm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bpfm_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import bpfm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    logic [PAT_BYTES-1:0][7:0] pattern_reg;
    logic [LEN_CFG_W-1:0]      len_cfg_reg;
    logic [LEN_W-1:0]          used_len;
    logic [LEN_CFG_W:0]        len_raw;
    bpfm_ctrl_t                ctrl;
    logic [MAX_PATTERN:0][7:0] chain;
    logic [MAX_PATTERN-1:0]    hits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            len_cfg_reg <= LEN_CFG_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_PATTERN_LOW:      pattern_reg[7:0]   <= cfg_wr_data;
                CFG_PATTERN_MID_LOW:  pattern_reg[15:8]  <= cfg_wr_data;
                CFG_PATTERN_MID_HIGH: pattern_reg[23:16] <= cfg_wr_data;
                CFG_PATTERN_HIGH:     pattern_reg[31:24] <= cfg_wr_data;
                CFG_PATTERN_LENGTH:   len_cfg_reg <= cfg_wr_data[LEN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        len_raw = {1'b0, len_cfg_reg};
        if (len_raw == '0) begin
            used_len = LEN_W'(1);
        end else if (len_raw > (LEN_CFG_W + 1)'(MAX_PATTERN)) begin
            used_len = LEN_W'(MAX_PATTERN);
        end else begin
            used_len = LEN_W'(len_raw);
        end
    end

    assign s_ready   = !m_valid || m_ready || !s_data.last_byte;
    assign ctrl.step = s_valid && s_ready;
    assign ctrl.last = s_data.last_byte;
    assign chain[0]  = s_data.data_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        bpfm_cell #(
            .CELL_IDX    (k),
            .MAX_PATTERN (MAX_PATTERN),
            .LEN_W       (LEN_W)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .byte_in  (chain[k]),
            .pattern  (pattern_reg),
            .used_len (used_len),
            .byte_out (chain[k+1]),
            .hit      (hits[k])
        );
    end

    bpfm_tracker #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_tracker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .window_match (&hits),
        .used_len     (used_len),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_data       (m_data)
    );

endmodule

`default_nettype wire

@@ rtl/core/bpfm_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpfm_cell #(
    parameter int CELL_IDX    = 0,
    parameter int MAX_PATTERN = bpfm_pkg::DEFAULT_MAX_PATTERN,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire bpfm_pkg::bpfm_ctrl_t                ctrl,
    input  wire logic [7:0]                          byte_in,
    input  wire logic [bpfm_pkg::PAT_BYTES-1:0][7:0] pattern,
    input  wire logic [LEN_W-1:0]                    used_len,
    output logic [7:0]                               byte_out,
    output logic                                     hit
);
    import bpfm_pkg::*;

    logic [7:0]           byte_reg;
    logic                 in_use;
    logic [LEN_W-1:0]     pat_pos;
    logic [PAT_IDX_W-1:0] pat_sel;
    logic [7:0]           expected;

    // window slot k lines up with pattern byte len-1-k
    assign in_use  = LEN_W'(CELL_IDX) < used_len;
    assign pat_pos = used_len - LEN_W'(CELL_IDX + 1);
    assign pat_sel = PAT_IDX_W'(pat_pos);

    always_comb begin
        if (32'(pat_pos) < 32'(PAT_BYTES)) begin
            expected = pattern[pat_sel];
        end else begin
            expected = 8'h00;
        end
    end

    assign hit = !in_use || (byte_in == expected);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'h00;
        end else if (ctrl.step) begin
            if (ctrl.last) begin
                byte_reg <= 8'h00;
            end else begin
                byte_reg <= byte_in;
            end
        end
    end

    assign byte_out = byte_reg;

endmodule

`default_nettype wire

@@ rtl/core/bpfm_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bpfm_tracker #(
    parameter int MAX_PATTERN = bpfm_pkg::DEFAULT_MAX_PATTERN,
    parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire bpfm_pkg::bpfm_ctrl_t ctrl,
    input  wire logic                 window_match,
    input  wire logic [LEN_W-1:0]     used_len,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output bpfm_pkg::bpfm_out_t       m_data
);
    import bpfm_pkg::*;

    logic [COUNT_W-1:0] seen_reg, seen_next;
    logic               have_reg, have_next;
    logic [COUNT_W-1:0] offset_reg, offset_next;
    logic               m_valid_reg;
    bpfm_out_t          m_data_reg;
    bpfm_out_t          result;
    logic [COUNT_W-1:0] seen_inc;
    logic [COUNT_W-1:0] len_ext;

    assign seen_inc = seen_reg + COUNT_W'(1);
    assign len_ext  = COUNT_W'(used_len);

    always_comb begin
        seen_next   = seen_reg;
        have_next   = have_reg;
        offset_next = offset_reg;
        if (seen_reg != {COUNT_W{1'b1}}) begin
            seen_next = seen_inc;
            if (!have_reg && (seen_inc >= len_ext) && window_match) begin
                have_next   = 1'b1;
                offset_next = seen_inc - len_ext;
            end
        end
        result.match_found  = have_next;
        result.match_offset = have_next ? offset_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            have_reg    <= 1'b0;
            offset_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctrl.step) begin
                if (ctrl.last) begin
                    seen_reg   <= '0;
                    have_reg   <= 1'b0;
                    offset_reg <= '0;
                end else begin
                    seen_reg   <= seen_next;
                    have_reg   <= have_next;
                    offset_reg <= offset_next;
                end
            end
            if (ctrl.step && ctrl.last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.step && ctrl.last) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
